@@ rtl/alkc_pkg.sv @@
`timescale 1ns / 1ps

package alkc_pkg;

    localparam int NUM_KEYS = 6;
    localparam int SAMPLE_W = 10;
    localparam int TICKS_W  = 16;
    localparam int CODE_W   = 3;

    localparam logic [CODE_W-1:0] KEY_SQUELCH = 3'd0;
    localparam logic [CODE_W-1:0] KEY_PTY     = 3'd4;
    localparam logic [CODE_W-1:0] KEY_LAST    = 3'd5;
    localparam logic [CODE_W-1:0] KEY_NONE    = 3'd7;

    localparam logic [SAMPLE_W:0] MATCH_HALF   = 11'd15;
    localparam logic [SAMPLE_W:0] RELEASE_HALF = 11'd50;

    // Register map, index = paddr[4:2]
    localparam logic [2:0] REG_PRESS_LEVEL = 3'd0;
    localparam logic [2:0] REG_CENTRE_SQL  = 3'd1;
    localparam logic [2:0] REG_CENTRE_UP   = 3'd2;
    localparam logic [2:0] REG_CENTRE_DOWN = 3'd3;
    localparam logic [2:0] REG_CENTRE_VOX  = 3'd4;
    localparam logic [2:0] REG_CENTRE_PTY  = 3'd5;
    localparam logic [2:0] REG_CENTRE_AFM  = 3'd6;
    localparam logic [2:0] REG_LONG_TICKS  = 3'd7;

    localparam logic [SAMPLE_W-1:0] PRESS_LEVEL_RST = 10'd864;
    localparam logic [TICKS_W-1:0]  LONG_TICKS_RST  = 16'd60;

    typedef logic [NUM_KEYS-1:0][SAMPLE_W-1:0] centre_arr_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] first_sample;
        logic [SAMPLE_W-1:0] confirm_sample;
    } item_t;

    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic              is_long;
    } result_t;

    // Classified request handed from front to back
    typedef struct packed {
        logic [CODE_W-1:0]   key;
        logic [NUM_KEYS-1:0] near_release;
    } class_t;

    typedef struct packed {
        logic              waiting;
        logic [CODE_W-1:0] held_key;
    } back_stat_t;

    localparam int CLASS_W  = $bits(class_t);
    localparam int RESULT_W = $bits(result_t);

endpackage

@@ rtl/adc_ladder_key_press_classifier_core.sv @@
`timescale 1ns / 1ps

// ADC resistor-ladder keypad decoder.
// Input queue side: drive item (first and confirming ADC read of one poll
// tick) and raise push; the request is taken on a clock edge with push high
// and full low. Result queue side: while empty is low, result holds the
// oldest key event (key_code, is_long); raise pop to take it. A tick yields
// zero or one event: short on release, long after long_press_ticks held
// ticks, instant for the pty key.
// Throughput is one request per cycle while full is low. The front
// classifies a request in the cycle it is pushed and writes it into a small
// queue; the back, when the output queue has room, updates the key state
// from the queue head and writes any event into the output queue, from
// which the receiver pops it.
// When the receiver stalls, results collect in the output queue; once it is
// full the back holds, the middle queue fills and full rises. Nothing drops.
// Reset clears both queues, loads the register defaults (press level 864,
// centres 64..704 in steps of 128, long press 60 ticks) and leaves no key
// held. APB registers at byte address 4*index; write only while idle.

module adc_ladder_key_press_classifier_core
    import alkc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  item_t       item,
    output logic        full,
    input  logic        pop,
    output result_t     result,
    output logic        empty,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [SAMPLE_W-1:0] press_level_reg;
    centre_arr_t         centre_reg;
    logic [TICKS_W-1:0]  long_ticks_reg;
    logic [2:0]          reg_idx;
    logic                cfg_wr;

    class_t              cls_front;
    class_t              cls_head;
    logic [CLASS_W-1:0]  cls_head_bits;
    logic                mid_empty;
    logic                cls_pop;
    result_t             res_back;
    logic                res_push;
    logic                out_full;
    logic [RESULT_W-1:0] result_bits;
    back_stat_t          stat;

    // Configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_level_reg <= PRESS_LEVEL_RST;
            centre_reg[0]   <= 10'd64;
            centre_reg[1]   <= 10'd192;
            centre_reg[2]   <= 10'd320;
            centre_reg[3]   <= 10'd448;
            centre_reg[4]   <= 10'd576;
            centre_reg[5]   <= 10'd704;
            long_ticks_reg  <= LONG_TICKS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_PRESS_LEVEL: press_level_reg <= pwdata[SAMPLE_W-1:0];
                REG_CENTRE_SQL:  centre_reg[0]   <= pwdata[SAMPLE_W-1:0];
                REG_CENTRE_UP:   centre_reg[1]   <= pwdata[SAMPLE_W-1:0];
                REG_CENTRE_DOWN: centre_reg[2]   <= pwdata[SAMPLE_W-1:0];
                REG_CENTRE_VOX:  centre_reg[3]   <= pwdata[SAMPLE_W-1:0];
                REG_CENTRE_PTY:  centre_reg[4]   <= pwdata[SAMPLE_W-1:0];
                REG_CENTRE_AFM:  centre_reg[5]   <= pwdata[SAMPLE_W-1:0];
                REG_LONG_TICKS:  long_ticks_reg  <= pwdata[TICKS_W-1:0];
                default:         press_level_reg <= press_level_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PRESS_LEVEL: prdata = 32'(press_level_reg);
            REG_CENTRE_SQL:  prdata = 32'(centre_reg[0]);
            REG_CENTRE_UP:   prdata = 32'(centre_reg[1]);
            REG_CENTRE_DOWN: prdata = 32'(centre_reg[2]);
            REG_CENTRE_VOX:  prdata = 32'(centre_reg[3]);
            REG_CENTRE_PTY:  prdata = 32'(centre_reg[4]);
            REG_CENTRE_AFM:  prdata = 32'(centre_reg[5]);
            REG_LONG_TICKS:  prdata = 32'(long_ticks_reg);
            default:         prdata = '0;
        endcase
    end

    // Front: classify the incoming request against the key windows
    alkc_front u_front (
        .item        (item),
        .press_level (press_level_reg),
        .centres     (centre_reg),
        .cls         (cls_front)
    );

    // Middle queue decouples classification from the key state machine
    alkc_fifo #(
        .WIDTH (CLASS_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls_front),
        .rd_en   (cls_pop),
        .rd_data (cls_head_bits),
        .full    (full),
        .empty   (mid_empty)
    );

    assign cls_head = class_t'(cls_head_bits);

    // Back: advance held key, countdown and release wait
    alkc_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cls              (cls_head),
        .cls_valid        (!mid_empty),
        .out_ready        (!out_full),
        .long_press_ticks (long_ticks_reg),
        .cls_pop          (cls_pop),
        .res_push         (res_push),
        .res              (res_back),
        .stat             (stat)
    );

    // Output queue holds events while the receiver stalls
    alkc_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_back),
        .rd_en   (pop),
        .rd_data (result_bits),
        .full    (out_full),
        .empty   (empty)
    );

    assign result = result_t'(result_bits);

    // Only real key codes ever leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.key_code <= KEY_LAST))
        else $error("result carries a code outside the key set");

    // The pty key never produces a long event
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.is_long) |-> (result.key_code != KEY_PTY))
        else $error("long event on pty key");

    // During a release wait only pty or no key can be held
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.waiting |-> (stat.held_key == KEY_NONE || stat.held_key == KEY_PTY))
        else $error("release wait with a long-capable key held");

    // An accepted request is present in the middle queue next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> !mid_empty)
        else $error("accepted request lost before the back");

endmodule

@@ rtl/alkc_fifo.sv @@
`timescale 1ns / 1ps

module alkc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/alkc_front.sv @@
`timescale 1ns / 1ps

module alkc_front
    import alkc_pkg::*;
(
    input  item_t               item,
    input  logic [SAMPLE_W-1:0] press_level,
    input  centre_arr_t         centres,
    output class_t              cls
);

    logic [SAMPLE_W:0]   s_ext;
    logic [NUM_KEYS-1:0] hit;
    logic [NUM_KEYS-1:0] near_rel;
    logic [CODE_W-1:0]   key;
    logic                pressed;

    assign s_ext   = {1'b0, item.confirm_sample};
    assign pressed = (item.first_sample < press_level);

    // Open windows: centre - half < sample < centre + half
    always_comb
    begin
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            hit[i]      = (s_ext + MATCH_HALF > {1'b0, centres[i]})
                       && (s_ext < {1'b0, centres[i]} + MATCH_HALF);
            near_rel[i] = (s_ext + RELEASE_HALF > {1'b0, centres[i]})
                       && (s_ext < {1'b0, centres[i]} + RELEASE_HALF);
        end
    end

    // Lowest matching code wins
    always_comb
    begin
        key = KEY_NONE;
        for (int i = NUM_KEYS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                key = CODE_W'(i);
            end
        end
        if (!pressed)
        begin
            key = KEY_NONE;
        end
    end

    assign cls.key          = key;
    assign cls.near_release = near_rel;

endmodule

@@ rtl/alkc_back.sv @@
`timescale 1ns / 1ps

module alkc_back
    import alkc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  class_t             cls,
    input  logic               cls_valid,
    input  logic               out_ready,
    input  logic [TICKS_W-1:0] long_press_ticks,
    output logic               cls_pop,
    output logic               res_push,
    output result_t            res,
    output back_stat_t         stat
);

    logic [CODE_W-1:0]  held_key_reg, held_key_next;
    logic [TICKS_W-1:0] countdown_reg, countdown_next;
    logic               waiting_reg, waiting_next;
    logic [CODE_W-1:0]  waited_key_reg, waited_key_next;
    logic [CODE_W-1:0]  wsel;
    logic [TICKS_W-1:0] dec;
    logic               go;
    logic               emit;

    assign go      = cls_valid && out_ready;
    assign cls_pop = go;
    assign wsel    = (waited_key_reg <= KEY_LAST) ? waited_key_reg : KEY_SQUELCH;
    assign dec     = (countdown_reg != '0) ? countdown_reg - 1'b1 : countdown_reg;

    always_comb
    begin
        held_key_next   = held_key_reg;
        countdown_next  = countdown_reg;
        waiting_next    = waiting_reg;
        waited_key_next = waited_key_reg;
        emit            = 1'b0;
        res.key_code    = cls.key;
        res.is_long     = 1'b0;
        if (waiting_reg)
        begin
            if (!cls.near_release[wsel])
            begin
                waiting_next = 1'b0;
            end
        end
        else if (cls.key == KEY_NONE)
        begin
            // release: short event for the last held key unless that is pty or no key
            emit           = (held_key_reg <= KEY_LAST) && (held_key_reg != KEY_PTY);
            res.key_code   = held_key_reg;
            held_key_next  = KEY_NONE;
            countdown_next = long_press_ticks;
        end
        else if (cls.key == KEY_PTY)
        begin
            emit            = 1'b1;
            held_key_next   = KEY_PTY;
            waiting_next    = 1'b1;
            waited_key_next = KEY_PTY;
        end
        else
        begin
            held_key_next  = cls.key;
            countdown_next = dec;
            if (dec == '0)
            begin
                emit            = 1'b1;
                res.is_long     = 1'b1;
                held_key_next   = KEY_NONE;
                countdown_next  = long_press_ticks;
                waiting_next    = 1'b1;
                waited_key_next = cls.key;
            end
        end
    end

    assign res_push      = go && emit;
    assign stat.waiting  = waiting_reg;
    assign stat.held_key = held_key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_key_reg   <= KEY_NONE;
            countdown_reg  <= LONG_TICKS_RST;
            waiting_reg    <= 1'b0;
            waited_key_reg <= KEY_SQUELCH;
        end
        else if (go)
        begin
            held_key_reg   <= held_key_next;
            countdown_reg  <= countdown_next;
            waiting_reg    <= waiting_next;
            waited_key_reg <= waited_key_next;
        end
    end

endmodule

@@ sim/adc_ladder_key_press_classifier_core_test.sv @@
`timescale 1ns / 1ps

module adc_ladder_key_press_classifier_core_test;
    import alkc_pkg::*;

    localparam int STALL_LIMIT = 2000;   // cycles without any handshake
    localparam int LONG_HOLD   = 400;    // receiver hold-off to back the block up
    localparam int POST_DRAIN  = 6;      // pad the drain for requests still in the queues
    localparam int MAX_SAMPLE  = (1 << SAMPLE_W) - 1;

    // Keypad event predictor: tracks the held key, the shared long-press
    // countdown and the release wait, and queues the events each tick causes.
    class key_event_scoreboard;
        logic [SAMPLE_W-1:0] press_level;
        logic [SAMPLE_W-1:0] centre [NUM_KEYS];
        logic [TICKS_W-1:0]  long_ticks;
        logic [CODE_W-1:0]   held_key;
        logic [TICKS_W-1:0]  countdown;
        bit                  waiting;
        logic [CODE_W-1:0]   waited_key;
        result_t             key_events [$];
        int                  errors;

        function new();
            press_level = PRESS_LEVEL_RST;
            for (int i = 0; i < NUM_KEYS; i++)
                centre[i] = SAMPLE_W'(64 + 128 * i);
            long_ticks = LONG_TICKS_RST;
            held_key   = KEY_NONE;
            countdown  = LONG_TICKS_RST;
            waiting    = 1'b0;
            waited_key = KEY_SQUELCH;
            errors     = 0;
        endfunction

        // Open window: strictly inside center +/- half.
        function bit near(int s, int c, int half);
            return (c - half < s) && (s < c + half);
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            if (idx == REG_PRESS_LEVEL)
                press_level = val[SAMPLE_W-1:0];
            else if (idx == REG_LONG_TICKS)
                long_ticks = val[TICKS_W-1:0];
            else
                centre[idx - REG_CENTRE_SQL] = val[SAMPLE_W-1:0];
        endfunction

        function void add_event(logic [CODE_W-1:0] code, logic is_long);
            result_t ev;
            ev.key_code = code;
            ev.is_long  = is_long;
            key_events.push_back(ev);
        endfunction

        function void note_tick(item_t it);
            logic [CODE_W-1:0] key;
            int                w;
            int                conf;
            conf = int'(it.confirm_sample);
            // Release wait: only watch for the confirming read leaving the key.
            if (waiting)
            begin
                w = (waited_key <= KEY_LAST) ? int'(waited_key) : 0;
                if (!near(conf, int'(centre[w]), int'(RELEASE_HALF)))
                    waiting = 1'b0;
                return;
            end
            key = KEY_NONE;
            if (it.first_sample < press_level)
            begin
                for (int i = NUM_KEYS - 1; i >= 0; i--)
                    if (near(conf, int'(centre[i]), int'(MATCH_HALF)))
                        key = CODE_W'(i);
            end
            if (key == KEY_NONE)
            begin
                if (held_key <= KEY_LAST && held_key != KEY_PTY)
                    add_event(held_key, 1'b0);
                held_key  = KEY_NONE;
                countdown = long_ticks;
                return;
            end
            if (key == KEY_PTY)
            begin
                held_key   = KEY_PTY;
                add_event(KEY_PTY, 1'b0);
                waiting    = 1'b1;
                waited_key = KEY_PTY;
                return;
            end
            held_key = key;
            if (countdown != 0)
                countdown = countdown - 1'b1;
            if (countdown == 0)
            begin
                add_event(key, 1'b1);
                held_key   = KEY_NONE;
                countdown  = long_ticks;
                waiting    = 1'b1;
                waited_key = key;
            end
        endfunction

        function void check_event(result_t got);
            result_t want;
            if (key_events.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: key event code %0d long %0b with none pending",
                             $time, got.key_code, got.is_long);
                return;
            end
            want = key_events.pop_front();
            if (got.key_code !== want.key_code || got.is_long !== want.is_long)
            begin
                errors++;
                if (errors <= 10)
                    $display({"%0t: key event expected code %0d long %0b, ",
                              "got code %0d long %0b"},
                             $time, want.key_code, want.is_long,
                             got.key_code, got.is_long);
            end
        endfunction

        function int pending();
            return key_events.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    item_t       item;
    logic        full;
    logic        pop;
    result_t     result;
    logic        empty;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    key_event_scoreboard sb;
    bit tx_burst;
    bit tx_rush;
    bit rx_burst;
    bit long_hold_req;
    int idle_cycles;

    adc_ladder_key_press_classifier_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .full    (full),
        .pop     (pop),
        .result  (result),
        .empty   (empty),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Monitor: both handshakes are judged on values held just before the edge.
    // Check the result first; a request taken at this edge cannot yet have an
    // event on the result ports.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                sb.check_event(result);
            if (push && !full)
                sb.note_tick(item);
        end
    end

    // Watchdog: count cycles with no request, no result and no register access.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || psel)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Receiver: draw a wait per result, occasionally run in bursts with no
    // wait, and take one long hold-off on request so the block backs up.
    initial
    begin
        int gap;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                gap = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 31) == 0)
                    rx_burst = !rx_burst;
                gap = rx_burst ? 0 : $urandom_range(0, 15);
            end
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty !== 1'b0);
        end
    end

    function automatic int clamp_sample(int v);
        return (v < 0) ? 0 : ((v > MAX_SAMPLE) ? MAX_SAMPLE : v);
    endfunction

    // Pick a read at least 50 away from c where one turns up quickly.
    function automatic int far_from(int c);
        int v;
        v = $urandom_range(0, MAX_SAMPLE);
        repeat (8)
        begin
            if (v <= c - 50 || v >= c + 50)
                return v;
            v = $urandom_range(0, MAX_SAMPLE);
        end
        return v;
    endfunction

    // Offer one tick request and hold it until the block takes it.
    task automatic send_tick(int f, int c);
        int    gap;
        item_t it;
        it.first_sample   = f[SAMPLE_W-1:0];
        it.confirm_sample = c[SAMPLE_W-1:0];
        if ($urandom_range(0, 31) == 0)
            tx_burst = !tx_burst;
        gap = (tx_burst || tx_rush) ? 0 : $urandom_range(0, 15);
        @(negedge clk);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        item <= it;
        do @(posedge clk); while (full !== 1'b0);
    endtask

    // Drop push and wait until every predicted event has come out, then give
    // any request still in flight that causes no event time to retire.
    task automatic drain_events();
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (POST_DRAIN) @(posedge clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        sb.write_reg(idx, val);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_setting(int lvl, int cs [NUM_KEYS], int ticks);
        logic [2:0] idx;
        drain_events();
        cfg_write(REG_PRESS_LEVEL, lvl);
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            idx = REG_CENTRE_SQL + i[2:0];
            cfg_write(idx, cs[i]);
        end
        cfg_write(REG_LONG_TICKS, ticks);
    endtask

    // Well-formed press: hold a key (sometimes sliding to another), linger
    // near it for the release wait, then let go.
    task automatic send_gesture(output int n);
        int k;
        int c;
        int lvl;
        int hold;
        int stay;
        lvl = int'(sb.press_level);
        k = $urandom_range(0, NUM_KEYS - 1);
        c = int'(sb.centre[k]);
        if (sb.long_ticks <= 64 && $urandom_range(0, 5) == 0)
            hold = int'(sb.long_ticks) + 2;
        else if (sb.long_ticks <= 8)
            hold = $urandom_range(1, int'(sb.long_ticks) + 3);
        else
            hold = $urandom_range(1, 6);
        stay = $urandom_range(0, 3);
        n = hold + stay + 1;
        for (int j = 0; j < hold; j++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                k = $urandom_range(0, NUM_KEYS - 1);
                c = int'(sb.centre[k]);
            end
            send_tick((lvl > 0) ? $urandom_range(0, lvl - 1) : 0,
                      clamp_sample(c + $urandom_range(0, 28) - 14));
        end
        for (int j = 0; j < stay; j++)
            send_tick($urandom_range(0, MAX_SAMPLE),
                      clamp_sample(c + $urandom_range(0, 98) - 49));
        send_tick($urandom_range(lvl, MAX_SAMPLE), far_from(c));
    endtask

    // Mostly well-formed presses with random content, the rest raw noise.
    task automatic run_random(int count);
        int sent;
        int n;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                send_tick($urandom_range(0, MAX_SAMPLE), $urandom_range(0, MAX_SAMPLE));
                sent++;
            end
            else
            begin
                send_gesture(n);
                sent += n;
            end
        end
    endtask

    initial
    begin
        int rc [NUM_KEYS];
        sb            = new();
        rst_n         = 1'b0;
        push          = 1'b0;
        item          = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tx_burst      = 1'b0;
        tx_rush       = 1'b0;
        rx_burst      = 1'b0;
        long_hold_req = 1'b0;
        idle_cycles   = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset defaults: window edges, press level edge, each key, pty.
        send_tick(0, 64);          // squelch held, extreme first read
        send_tick(863, 50);        // just below press level, low window edge
        send_tick(864, 64);        // at press level: no key, short squelch
        send_tick(100, 79);        // just outside the squelch window
        send_tick(100, 78);        // high window edge
        send_tick(1023, 1023);     // release: short squelch
        send_tick(500, 192);       // up
        send_tick(1023, 0);        // release: short up
        send_tick(10, 320);        // down
        send_tick(10, 128);        // between keys: short down
        send_tick(10, 448);        // vox
        send_tick(1023, 512);      // short vox
        send_tick(10, 704);        // afm
        send_tick(900, 704);       // short afm
        send_tick(10, 576);        // pty fires at once
        send_tick(10, 625);        // still inside the release window
        send_tick(10, 626);        // leaves it; tick ends quietly
        send_tick(1023, 1023);     // pty held: nothing on release

        // Long press of two ticks. The countdown still holds the old reload
        // until a no-key tick, so reload it first.
        apply_setting(864, '{64, 192, 320, 448, 576, 704}, 2);
        send_tick(1023, 0);
        send_tick(5, 64);
        send_tick(5, 64);          // long squelch, release wait starts
        send_tick(5, 113);         // within 50: keep waiting
        send_tick(5, 114);         // leave
        send_tick(5, 192);         // up, countdown shared
        send_tick(5, 320);         // slide to down: long down
        send_tick(5, 1023);        // leave
        send_tick(5, 448);
        send_tick(1023, 0);        // short vox

        // Back the block up: long receiver hold while requests keep coming.
        long_hold_req = 1'b1;
        tx_rush = 1'b1;
        repeat (8)
        begin
            send_tick(3, 192);
            send_tick(1023, 1023);
        end
        tx_rush = 1'b0;
        run_random(90);

        // Extremes: highest press level, centers at both rails with
        // overlapping windows, shortest long press.
        apply_setting(1023, '{0, 1023, 15, 1008, 512, 300}, 1);
        run_random(80);

        // Nothing can be pressed; longest long press.
        apply_setting(0, '{100, 200, 300, 400, 500, 600}, 65535);
        run_random(25);

        // Crowded ladder: lowest code wins among overlapping windows.
        apply_setting(700, '{500, 510, 520, 530, 540, 550}, 65535);
        run_random(60);

        // Reset values again, with a pause for every event mid-way.
        apply_setting(864, '{64, 192, 320, 448, 576, 704}, 60);
        run_random(55);
        drain_events();
        run_random(55);

        // Random ladder.
        for (int i = 0; i < NUM_KEYS; i++)
            rc[i] = $urandom_range(0, MAX_SAMPLE);
        apply_setting($urandom_range(600, MAX_SAMPLE), rc, $urandom_range(1, 6));
        run_random(85);

        drain_events();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
